[rtl/lzsd_pkg.sv]
package lzsd_pkg;

  localparam int WIN_AW    = 12;
  localparam int WIN_BYTES = 1 << WIN_AW;
  localparam int CNT_W     = WIN_AW + 1;
  localparam int RUN_W     = 5;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [15:0] FLAG_FILL  = 16'hff00;

  localparam logic [WIN_AW-1:0] START_POS_RESET   = 12'd4078;
  localparam logic [3:0]        LENGTH_BIAS_RESET = 4'd2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIAS = 4'd1;

  typedef enum logic [1:0] {
    PH_TOKEN      = 2'd0,
    PH_AFTER_FLAG = 2'd1,
    PH_MATCH2     = 2'd2
  } phase_t;

  typedef struct packed {
    logic              restart;
    logic [WIN_AW-1:0] start_pos;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
  } win_req_t;

endpackage

[rtl/lzsd_window.sv]
module lzsd_window (
  input  logic                        clk,
  input  logic                        rst,
  input  lzsd_pkg::win_req_t          req,
  output logic [lzsd_pkg::WIN_AW-1:0] wr_pos,
  output logic [7:0]                  rd_data
);
  import lzsd_pkg::*;

  logic [7:0]        mem [WIN_BYTES];
  logic [7:0]        mem_q;
  logic              ok_q;
  logic [WIN_AW-1:0] base;
  logic [CNT_W-1:0]  fill;
  logic [WIN_AW-1:0] rel;

  // entries written since the last stream start form one run from base
  assign rel = req.rd_addr - base;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_pos] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= START_POS_RESET;
      base   <= START_POS_RESET;
      fill   <= '0;
      ok_q   <= 1'b0;
    end else begin
      if (req.rd_en) begin
        ok_q <= ({1'b0, rel} < fill);
      end
      if (req.restart) begin
        wr_pos <= req.start_pos;
        base   <= req.start_pos;
        fill   <= '0;
      end else if (req.wr_en) begin
        wr_pos <= wr_pos + 1'b1;
        if (fill != CNT_W'(WIN_BYTES)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  assign rd_data = ok_q ? mem_q : SPACE_CHAR;

endmodule

[rtl/lzss_byte_stream_decoder.sv]
// channel | signals                          | direction | accepted when
// in      | in_byte, stream_start            | input     | in_valid & in_ready
// out     | out_byte, last_of_run            | output    | out_valid & out_ready
// cfg     | cfg_index, cfg_data              | input     | cfg_valid & cfg_ready
//
// Flag bytes, first match bytes and literals do not hold the input.
// A match copies 1..31 bytes, one per cycle while the output takes them,
// through the single window read port, and holds the input until all are read.
// Reset is synchronous; the window reads as spaces through a fill count, so
// neither reset nor stream start needs a clearing pass.
// A stalled output holds the byte pipeline and with it the input.
module lzss_byte_stream_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            stream_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lzsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lzsd_pkg::*;

  logic [WIN_AW-1:0] start_position;
  logic [3:0]        length_bias;

  phase_t      phase, phase_next, ph_cur;
  logic [15:0] flag_shift, flag_next, fs_cur, fs_shift;
  logic [7:0]  offset_low, olb_next, olb_cur;
  logic        tok, lit, copy_start;

  logic [WIN_AW-1:0] src;
  logic [RUN_W-1:0]  remaining;

  // byte stage: data comes from the window read or is carried in s2_data
  logic       s2_valid, s2_fwd, s2_last;
  logic [7:0] s2_data, s2_byte;
  logic       s2_adv, copy_issue, in_acc, hit;

  win_req_t          wreq;
  logic [WIN_AW-1:0] wr_pos;
  logic [7:0]        win_rdata;

  lzsd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .req     (wreq),
    .wr_pos  (wr_pos),
    .rd_data (win_rdata)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= START_POS_RESET;
      length_bias    <= LENGTH_BIAS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_POS:   start_position <= cfg_data[WIN_AW-1:0];
        CFG_LENGTH_BIAS: length_bias    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s2_byte    = s2_fwd ? s2_data : win_rdata;
  assign s2_adv     = s2_valid && (!out_valid || out_ready);
  assign copy_issue = (remaining != '0) && (!s2_valid || s2_adv);
  assign in_ready   = (remaining == '0) && (!s2_valid || s2_adv);
  assign in_acc     = in_valid && in_ready;
  // read of the entry being written this same cycle
  assign hit        = s2_adv && (src == wr_pos);

  // parser: stream start resets the parse state before the byte is used
  assign ph_cur  = stream_start ? PH_TOKEN : phase;
  assign fs_cur  = stream_start ? 16'h0000 : flag_shift;
  assign olb_cur = stream_start ? 8'h00 : offset_low;
  assign fs_shift = {1'b0, fs_cur[15:1]};

  always_comb begin
    tok        = 1'b0;
    copy_start = 1'b0;
    unique case (ph_cur)
      PH_MATCH2:     copy_start = 1'b1;
      PH_AFTER_FLAG: tok = 1'b1;
      default:       tok = fs_shift[8];
    endcase
    lit = tok && flag_next[0];
  end

  always_comb begin
    flag_next  = fs_cur;
    phase_next = ph_cur;
    olb_next   = olb_cur;
    unique case (ph_cur)
      PH_MATCH2:     phase_next = PH_TOKEN;
      PH_AFTER_FLAG: ;
      default: begin
        if (!fs_shift[8]) begin
          flag_next  = FLAG_FILL | {8'h00, in_byte};
          phase_next = PH_AFTER_FLAG;
        end else begin
          flag_next = fs_shift;
        end
      end
    endcase
    if (tok) begin
      if (flag_next[0]) begin
        phase_next = PH_TOKEN;
      end else begin
        olb_next   = in_byte;
        phase_next = PH_MATCH2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      flag_shift <= '0;
      offset_low <= '0;
      remaining  <= '0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase      <= phase_next;
        flag_shift <= flag_next;
        offset_low <= olb_next;
      end
      if (in_acc && copy_start) begin
        remaining <= RUN_W'(in_byte[3:0]) + RUN_W'(length_bias) + RUN_W'(1);
      end else if (copy_issue) begin
        remaining <= remaining - 1'b1;
      end
      if (copy_issue || (in_acc && lit)) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && copy_start) begin
      src <= {in_byte[7:4], olb_cur};
    end else if (copy_issue) begin
      src <= src + 1'b1;
    end
    if (copy_issue) begin
      s2_fwd  <= hit;
      s2_data <= s2_byte;
      s2_last <= (remaining == RUN_W'(1));
    end else if (in_acc && lit) begin
      s2_fwd  <= 1'b1;
      s2_data <= in_byte;
      s2_last <= 1'b1;
    end
    if (s2_adv) begin
      out_byte    <= s2_byte;
      last_of_run <= s2_last;
    end
  end

  always_comb begin
    wreq.restart   = in_acc && stream_start;
    wreq.start_pos = start_position;
    wreq.wr_en     = s2_adv;
    wreq.wr_data   = s2_byte;
    wreq.rd_en     = copy_issue;
    wreq.rd_addr   = src;
  end

  a_no_accept_during_copy: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> !in_ready)
    else $error("input taken while a copy is running");

  a_match_starts_copy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !stream_start && phase == PH_MATCH2) |=> (remaining != '0))
    else $error("match item did not start a copy");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_last) |-> (remaining == '0))
    else $error("last byte of run staged while copy bytes remain");

  a_single_source: assert property (@(posedge clk) disable iff (rst)
    !(copy_issue && in_acc))
    else $error("copy read and input item in the same cycle");

endmodule
